FILE: rtl/core/sha1_stream_hasher_macros.svh
// Assertion macros shared by the SHA-1 stream hasher
`ifndef SHA1_STREAM_HASHER_MACROS_SVH
`define SHA1_STREAM_HASHER_MACROS_SVH
// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked every clock outside reset
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/sha1_pkg.sv
// Package: SHA-1 constants, command and status types, round helpers
package sha1_pkg;
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned ROUNDS = 80;

    // commands from controller to datapath
    typedef struct packed {
        logic       put_byte;   // write bval at pos, count if count_en
        logic       count_en;
        logic       use_pad;    // byte is the 0x80 pad marker
        logic       put_len;    // write bit length into words 14 and 15
        logic       start;      // load a..e from chain
        logic       round;      // run one round
        logic [6:0] round_idx;
        logic       finish;     // add working vars into chain, clear schedule
        logic       shift_out;  // rotate chain to present next digest word
        logic       reinit;     // back to reset state for next message
    } sha1_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [5:0] pos;        // byte position inside block
    } sha1_stat_t;

    function automatic logic [31:0] sha1_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] r;
        if (t < 7'd20)      r = (b & c) | (~b & d);
        else if (t < 7'd40) r = b ^ c ^ d;
        else if (t < 7'd60) r = (b & c) | (b & d) | (c & d);
        else                r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)      r = K0;
        else if (t < 7'd40) r = K1;
        else if (t < 7'd60) r = K2;
        else                r = K3;
        return r;
    endfunction
endpackage

FILE: rtl/core/sha1_stream_hasher.sv
// Top level: streaming SHA-1 hasher, controller plus datapath
// A byte that fills no block is only stored; the byte that fills a block starts a compression.
// Last item: padding plus one or two 80-round compressions,
// then five digest words, one per accepted output transaction.
// Input is held off (in_ready low) while a block is compressed, padded or output.
// Reset (rst_n low, async) loads the initial hash words and clears the count.
`include "sha1_stream_hasher_macros.svh"
module sha1_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha1_pkg::*;

    sha1_cmd_t  cmd;
    sha1_stat_t stat;

    sha1_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .no_byte, .last,
        .out_valid, .out_ready, .word_index, .last_word, .stat, .cmd
    );

    sha1_datapath u_dp (
        .clk, .rst_n, .cmd, .data_byte, .stat, .digest_word
    );

    `SHA_ASSERT_IMP(a_no_in_during_out, out_valid, !in_ready, "input open during output")
    `SHA_ASSERT_IMP(a_idx_range, out_valid, word_index <= 3'd4, "word index out of range")
    `SHA_ASSERT_NEXT(a_done_idle, out_valid && out_ready && last_word, in_ready && !out_valid,
        "no return to idle after digest")
endmodule

FILE: rtl/core/sha1_datapath.sv
// Datapath: schedule buffer, chaining words, working variables, bit counter
module sha1_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1_pkg::sha1_cmd_t cmd,
    input  logic [7:0]         data_byte,
    output sha1_pkg::sha1_stat_t stat,
    output logic [31:0]        digest_word
);
    import sha1_pkg::*;

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] cnt_reg;

    logic [5:0]  pos;
    logic [3:0]  s, s2, s8, s13, widx;
    logic [4:0]  shift;
    logic [7:0]  bval;
    logic [31:0] wexp, wcur, tmp;

    assign pos  = cnt_reg[8:3];
    assign stat.pos = pos;
    assign digest_word = h_reg[0];
    assign s    = cmd.round_idx[3:0];
    assign s2   = s + 4'd2;
    assign s8   = s + 4'd8;
    assign s13  = s + 4'd13;
    assign widx = pos[5:2];
    assign shift = {~pos[1:0], 3'b000};
    assign bval = cmd.use_pad ? PAD_BYTE : data_byte;

    // on-the-fly expansion and round sum
    always_comb
    begin
        wexp = w_reg[s13] ^ w_reg[s8] ^ w_reg[s2] ^ w_reg[s];
        wcur = (cmd.round_idx >= 7'd16) ? {wexp[30:0], wexp[31]} : w_reg[s];
        tmp  = {a_reg[26:0], a_reg[31:27]} + sha1_f(cmd.round_idx, b_reg, c_reg, d_reg)
             + e_reg + sha1_k(cmd.round_idx) + wcur;
    end

    // control-carrying state: chain, schedule, counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
            h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.put_byte)
            begin
                w_reg[widx] <= (w_reg[widx] & ~(32'hFF << shift))
                             | ({24'd0, bval} << shift);
                if (cmd.count_en) cnt_reg <= cnt_reg + 64'd8;
            end
            if (cmd.put_len)
            begin
                w_reg[14] <= cnt_reg[63:32];
                w_reg[15] <= cnt_reg[31:0];
            end
            if (cmd.round) w_reg[s] <= wcur;
            if (cmd.finish)
            begin
                h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
                for (int i = 0; i < 16; i++) w_reg[i] <= '0;
            end
            // reinit wins over the final rotate
            if (cmd.reinit)
            begin
                h_reg[0] <= H0_INIT; h_reg[1] <= H1_INIT; h_reg[2] <= H2_INIT;
                h_reg[3] <= H3_INIT; h_reg[4] <= H4_INIT;
                cnt_reg <= '0;
            end
            else if (cmd.shift_out)
            begin
                for (int i = 0; i < 4; i++) h_reg[i] <= h_reg[i+1];
                h_reg[4] <= h_reg[0];
            end
        end
    end

    // working variables, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
            d_reg <= h_reg[3]; e_reg <= h_reg[4];
        end
        else if (cmd.round)
        begin
            e_reg <= d_reg; d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg; a_reg <= tmp;
        end
    end
endmodule

FILE: rtl/core/sha1_ctrl.sv
// Controller: sequences byte intake, compression rounds, padding and output
module sha1_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 no_byte,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           word_index,
    output logic                 last_word,
    input  sha1_pkg::sha1_stat_t stat,
    output sha1_pkg::sha1_cmd_t  cmd
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_PAD   = 3'd3;
    localparam logic [2:0] ST_LEN   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // after a compression: 0 back to idle, 1 go pad, 2 go length, 3 output
    localparam logic [1:0] NX_IDLE = 2'd0;
    localparam logic [1:0] NX_PAD  = 2'd1;
    localparam logic [1:0] NX_LEN  = 2'd2;
    localparam logic [1:0] NX_OUT  = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [1:0] nx_reg, nx_next;
    logic [2:0] idx_reg, idx_next;
    logic       acc;

    assign in_ready   = (state_reg == ST_IDLE);
    assign acc        = in_valid && in_ready;
    assign out_valid  = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd4);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        nx_next    = nx_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.round_idx = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    if (!no_byte)
                    begin
                        cmd.put_byte = 1'b1;
                        cmd.count_en = 1'b1;
                    end
                    if (!no_byte && stat.pos == 6'd63)
                    begin
                        cmd.start  = 1'b1;
                        rnd_next   = '0;
                        nx_next    = last ? NX_PAD : NX_IDLE;
                        state_next = ST_ROUND;
                    end
                    else if (last)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'(ROUNDS - 1)) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                unique case (nx_reg)
                    NX_IDLE: state_next = ST_IDLE;
                    NX_PAD:  state_next = ST_PAD;
                    NX_LEN:  state_next = ST_LEN;
                    NX_OUT:
                    begin
                        idx_next   = '0;
                        state_next = ST_OUT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_PAD:
            begin
                cmd.put_byte = 1'b1;
                cmd.use_pad  = 1'b1;
                if (stat.pos >= 6'd56)
                begin
                    cmd.start  = 1'b1;
                    rnd_next   = '0;
                    nx_next    = NX_LEN;
                    state_next = ST_ROUND;
                end
                else
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.put_len = 1'b1;
                cmd.start   = 1'b1;
                nx_next     = NX_OUT;
                rnd_next    = '0;
                state_next  = ST_ROUND;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd4)
                    begin
                        cmd.reinit = 1'b1;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state, round counter and output index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            nx_reg    <= NX_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            nx_reg    <= nx_next;
            idx_reg   <= idx_next;
        end
    end
endmodule
